[sv/prcm_pkg.sv]
`timescale 1ns / 1ps

package prcm_pkg;

    // Fractions in unsigned Q16 (value * 65536), nearest code
    localparam logic [16:0] Q_ONE = 17'd65536;
    localparam logic [16:0] Q_P10 = 17'd6554;
    localparam logic [15:0] Q_P25 = 16'd16384;
    localparam logic [16:0] Q_P30 = 17'd19661;
    localparam logic [16:0] Q_P40 = 17'd26214;
    localparam logic [15:0] Q_P45 = 16'd29491;
    localparam logic [16:0] Q_P50 = 17'd32768;
    localparam logic [16:0] Q_P70 = 17'd45875;
    localparam logic [16:0] Q_P80 = 17'd52429;
    localparam logic [16:0] Q_P90 = 17'd58982;

    // Lowest and highest alpha codes (0.25 and 0.70)
    localparam logic [15:0] A_MIN = 16'd16384;
    localparam logic [15:0] A_MAX = 16'd45875;

    // Breakpoints in 1/16 mm
    localparam logic [9:0] MM_0_5 = 10'd8;
    localparam logic [9:0] MM_2   = 10'd32;
    localparam logic [9:0] MM_5   = 10'd80;
    localparam logic [9:0] MM_10  = 10'd160;
    localparam logic [9:0] MM_20  = 10'd320;
    localparam logic [9:0] MM_40  = 10'd640;

    // Reciprocals, 22 fraction bits: exact floor for dividends below 2^19
    localparam int unsigned RECIP_SHIFT = 22;
    localparam logic [20:0] RECIP3 = 21'd1398102;
    localparam logic [20:0] RECIP5 = 21'd838861;

    typedef enum logic [2:0] {
        SEG_A,   // below 2 mm, ramp from 0.5 mm
        SEG_B,   // 2 to 5 mm
        SEG_C,   // 5 to 10 mm
        SEG_D,   // 10 to 20 mm
        SEG_E,   // 20 to 40 mm
        SEG_SAT  // 40 mm and above
    } t_seg;

    typedef struct packed {
        logic [9:0]  lo;
        logic [3:0]  sh;
        logic        div5;
        logic [16:0] base_r;
        logic [16:0] base_g;
        logic [16:0] base_b;
        logic [15:0] k_r;
        logic [15:0] k_g;
        logic [15:0] k_b;
        logic        dn_r;
        logic        dn_g;
        logic        dn_b;
    } t_seg_cfg;

    typedef struct packed {
        logic        trace;
        t_seg        seg;
        logic [18:0] x_t;
        logic [18:0] x_i;
    } t_s1;

    typedef struct packed {
        logic        trace;
        t_seg        seg;
        logic [15:0] t;
        logic [16:0] inten;
    } t_s2;

    typedef struct packed {
        logic        trace;
        t_seg        seg;
        logic [31:0] a_prod;
        logic [31:0] pr_r;
        logic [31:0] pr_g;
        logic [31:0] pr_b;
    } t_s3;

    typedef struct packed {
        logic        trace;
        logic [15:0] a;
        logic [16:0] c_r;
        logic [16:0] c_g;
        logic [16:0] c_b;
    } t_s4;

    typedef struct packed {
        logic        trace;
        logic [7:0]  alpha;
        logic [32:0] ca_r;
        logic [32:0] ca_g;
        logic [32:0] ca_b;
    } t_s5;

    typedef struct packed {
        logic [7:0] alpha_byte;
        logic [7:0] red_byte;
        logic [7:0] green_byte;
        logic [7:0] blue_byte;
    } t_pix;

    // Segment span 24/48 is 3 * 2^k, 80/160/320 is 5 * 2^k: shift then divide by 3 or 5
    function automatic t_seg_cfg seg_cfg(input t_seg seg);
        t_seg_cfg c;
        c = '0;
        unique case (seg)
            SEG_A: begin
                c.lo = MM_0_5; c.sh = 4'd13; c.div5 = 1'b0;
                c.base_r = Q_P10; c.base_g = Q_P50; c.base_b = Q_P10;
                c.k_g = Q_P30[15:0];
            end
            SEG_B: begin
                c.lo = MM_2; c.sh = 4'd12; c.div5 = 1'b0;
                c.base_r = Q_P10; c.base_g = Q_P80; c.base_b = Q_P10;
                c.k_r = Q_P80[15:0]; c.k_g = Q_P10[15:0]; c.dn_g = 1'b1;
            end
            SEG_C: begin
                c.lo = MM_5; c.sh = 4'd12; c.div5 = 1'b1;
                c.base_r = Q_P90; c.base_g = Q_P70; c.base_b = '0;
                c.k_r = Q_P10[15:0]; c.k_g = Q_P40[15:0]; c.dn_g = 1'b1;
            end
            SEG_D: begin
                c.lo = MM_10; c.sh = 4'd11; c.div5 = 1'b1;
                c.base_r = Q_ONE; c.base_g = Q_P30; c.base_b = '0;
                c.k_g = Q_P30[15:0]; c.dn_g = 1'b1;
            end
            SEG_E: begin
                c.lo = MM_20; c.sh = 4'd10; c.div5 = 1'b1;
                c.base_r = Q_ONE; c.base_g = '0; c.base_b = Q_P30;
                c.k_b = Q_P50[15:0];
            end
            default: begin
                c.lo = MM_40; c.sh = 4'd0; c.div5 = 1'b1;
                c.base_r = Q_P70; c.base_g = '0; c.base_b = Q_P80;
            end
        endcase
        return c;
    endfunction

endpackage

[sv/prcm_in_if.sv]
`timescale 1ns / 1ps

interface prcm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] precip_amount;

    modport source (output valid, output precip_amount, input ready);
    modport sink (input valid, input precip_amount, output ready);
endinterface

[sv/prcm_out_if.sv]
`timescale 1ns / 1ps

interface prcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] alpha_byte;
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;

    modport source (output valid, output alpha_byte, output red_byte,
                    output green_byte, output blue_byte, input ready);
    modport sink (input valid, input alpha_byte, input red_byte,
                  input green_byte, input blue_byte, output ready);
endinterface

[sv/precip_radar_colour_map_core.sv]
`timescale 1ns / 1ps
// Pipeline: six register stages, stage 1 to stage 6 in order; the result word is held in stage 6.
// Throughput: one word per cycle while not stalled; each stage holds only while the next is full.
// Reset: i_rst_n synchronous, active low, clears the stage valid bits only; no other state.
// Depth: each register stage is at most one multiply or one add deep; stalls come only
// from o_pix.ready.

module precip_radar_colour_map_core import prcm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    prcm_in_if.sink        i_pix,
    prcm_out_if.source     o_pix
);

    // Stage 1: pick the ramp segment, subtract its lower bound and align the
    //          offset so that the segment span becomes 3 or 5 times a power of two.
    // Stage 2: divide by 3 or 5 through a reciprocal with 22 fraction bits giving ramp position t
    //          and alpha intensity, both in Q16.
    // Stage 3: slope times t per channel, and 0.45 times intensity.
    // Stage 4: add or subtract the slope terms to the segment bases; form alpha.
    // Stage 5: channel times alpha; alpha times 255.
    // Stage 6: times 255 and keep bits 39..32; force a transparent pixel for a trace
    //          amount. This stage is the output register.
    // Each stage advances when the next one is empty or being emptied, so a bubble
    // is squeezed out and new words come in while a result is held, until all are full.

    logic  w_div_v, w_div_rdy;
    t_s2   w_div_d;
    logic  w_ramp_v, w_ramp_rdy;
    t_s4   w_ramp_d;
    t_pix  w_pix;

    prcm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pix.valid),
        .o_ready  (i_pix.ready),
        .i_amount (i_pix.precip_amount),
        .o_valid  (w_div_v),
        .i_ready  (w_div_rdy),
        .o_data   (w_div_d)
    );

    prcm_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_v),
        .o_ready (w_div_rdy),
        .i_data  (w_div_d),
        .o_valid (w_ramp_v),
        .i_ready (w_ramp_rdy),
        .o_data  (w_ramp_d)
    );

    prcm_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ramp_v),
        .o_ready (w_ramp_rdy),
        .i_data  (w_ramp_d),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_data  (w_pix)
    );

    // Drive the result word fields
    assign o_pix.alpha_byte = w_pix.alpha_byte;
    assign o_pix.red_byte   = w_pix.red_byte;
    assign o_pix.green_byte = w_pix.green_byte;
    assign o_pix.blue_byte  = w_pix.blue_byte;

`ifndef ASSERT_OFF
    // Only a trace amount gives zero alpha, and then the whole pixel is zero
    a_trace_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.alpha_byte == 8'd0) |->
            (o_pix.red_byte == 8'd0 && o_pix.green_byte == 8'd0 && o_pix.blue_byte == 8'd0))
        else $error("transparent pixel carries colour");

    // Alpha never exceeds 0.70 of full scale
    a_alpha_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.alpha_byte <= 8'd178))
        else $error("alpha above its ceiling");

    // Premultiplied channels never exceed alpha
    a_premul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.red_byte <= o_pix.alpha_byte)
                     && (o_pix.green_byte <= o_pix.alpha_byte)
                     && (o_pix.blue_byte <= o_pix.alpha_byte))
        else $error("channel above alpha");
`endif

endmodule

[sv/prcm_div.sv]
`timescale 1ns / 1ps

// Stages 1 and 2: classify the amount, then ramp position and intensity
// by reciprocal multiplication.
module prcm_div import prcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_amount,
    output logic        o_valid,
    input  logic        i_ready,
    output t_s2         o_data
);

    logic        r_v1, r_v2;
    t_s1         r_s1, n_s1;
    t_s2         r_s2, n_s2;
    logic        w_rdy1, w_rdy2;
    logic [9:0]  w_p10;
    logic [9:0]  w_d;
    t_seg_cfg    w_cfg1, w_cfg2;
    logic [20:0] w_recip;
    logic [39:0] w_prod_t, w_prod_i;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

    always_comb begin
        w_p10    = i_amount[9:0];
        n_s1.trace = (i_amount < 16'(MM_0_5));
        priority if (i_amount < 16'(MM_2)) begin
            n_s1.seg = SEG_A;
        end else if (i_amount < 16'(MM_5)) begin
            n_s1.seg = SEG_B;
        end else if (i_amount < 16'(MM_10)) begin
            n_s1.seg = SEG_C;
        end else if (i_amount < 16'(MM_20)) begin
            n_s1.seg = SEG_D;
        end else if (i_amount < 16'(MM_40)) begin
            n_s1.seg = SEG_E;
        end else begin
            n_s1.seg = SEG_SAT;
        end
        w_cfg1 = seg_cfg(n_s1.seg);
        // no ramp for trace or saturated amounts
        if (n_s1.trace || n_s1.seg == SEG_SAT) begin
            w_d = '0;
        end else begin
            w_d = w_p10 - w_cfg1.lo;
        end
        n_s1.x_t = 19'(w_d) << w_cfg1.sh;
        n_s1.x_i = (n_s1.seg == SEG_SAT) ? {MM_40, 9'd0} : {w_p10, 9'd0};
    end

    always_comb begin
        w_cfg2     = seg_cfg(r_s1.seg);
        w_recip    = w_cfg2.div5 ? RECIP5 : RECIP3;
        w_prod_t   = 40'(r_s1.x_t) * 40'(w_recip);
        w_prod_i   = 40'(r_s1.x_i) * 40'(RECIP5);
        n_s2.trace = r_s1.trace;
        n_s2.seg   = r_s1.seg;
        n_s2.t     = w_prod_t[RECIP_SHIFT +: 16];
        n_s2.inten = w_prod_i[RECIP_SHIFT +: 17];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) r_s1 <= n_s1;
        if (w_rdy2 && r_v1)    r_s2 <= n_s2;
    end

endmodule

[sv/prcm_ramp.sv]
`timescale 1ns / 1ps

// Stages 3 and 4: slope and alpha products, then channel values and alpha.
module prcm_ramp import prcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s2  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s4  o_data
);

    logic     r_v3, r_v4;
    t_s3      r_s3, n_s3;
    t_s4      r_s4, n_s4;
    logic     w_rdy3, w_rdy4;
    t_seg_cfg w_cfg3, w_cfg4;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = w_rdy3;
    assign o_valid = r_v4;
    assign o_data  = r_s4;

    always_comb begin
        w_cfg3      = seg_cfg(i_data.seg);
        n_s3.trace  = i_data.trace;
        n_s3.seg    = i_data.seg;
        n_s3.a_prod = 32'(Q_P45) * 32'(i_data.inten);
        n_s3.pr_r   = 32'(w_cfg3.k_r) * 32'(i_data.t);
        n_s3.pr_g   = 32'(w_cfg3.k_g) * 32'(i_data.t);
        n_s3.pr_b   = 32'(w_cfg3.k_b) * 32'(i_data.t);
    end

    always_comb begin
        w_cfg4     = seg_cfg(r_s3.seg);
        n_s4.trace = r_s3.trace;
        n_s4.a     = Q_P25 + r_s3.a_prod[31:16];
        n_s4.c_r   = w_cfg4.dn_r ? w_cfg4.base_r - {1'b0, r_s3.pr_r[31:16]}
                                 : w_cfg4.base_r + {1'b0, r_s3.pr_r[31:16]};
        n_s4.c_g   = w_cfg4.dn_g ? w_cfg4.base_g - {1'b0, r_s3.pr_g[31:16]}
                                 : w_cfg4.base_g + {1'b0, r_s3.pr_g[31:16]};
        n_s4.c_b   = w_cfg4.dn_b ? w_cfg4.base_b - {1'b0, r_s3.pr_b[31:16]}
                                 : w_cfg4.base_b + {1'b0, r_s3.pr_b[31:16]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy3) r_v3 <= i_valid;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) r_s3 <= n_s3;
        if (w_rdy4 && r_v3)    r_s4 <= n_s4;
    end

`ifndef ASSERT_OFF
    // Ramps stay inside the unit interval and alpha inside its band
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_s4.c_r <= Q_ONE) && (r_s4.c_g <= Q_ONE) && (r_s4.c_b <= Q_ONE)
                 && (r_s4.a >= A_MIN) && (r_s4.a <= A_MAX))
        else $error("channel or alpha out of range");
`endif

endmodule

[sv/prcm_blend.sv]
`timescale 1ns / 1ps

// Stages 5 and 6: premultiply by alpha, scale by 255 and truncate to bytes.
module prcm_blend import prcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s4  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_pix o_data
);

    logic        r_v5, r_v6;
    t_s5         r_s5, n_s5;
    t_pix        r_s6, n_s6;
    logic        w_rdy5, w_rdy6;
    logic [23:0] w_a255;
    logic [40:0] w_r255, w_g255, w_b255;

    assign w_rdy6  = !r_v6 || i_ready;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign o_ready = w_rdy5;
    assign o_valid = r_v6;
    assign o_data  = r_s6;

    always_comb begin
        w_a255     = {i_data.a, 8'd0} - 24'(i_data.a);
        n_s5.trace = i_data.trace;
        n_s5.alpha = w_a255[23:16];
        n_s5.ca_r  = 33'(i_data.c_r) * 33'(i_data.a);
        n_s5.ca_g  = 33'(i_data.c_g) * 33'(i_data.a);
        n_s5.ca_b  = 33'(i_data.c_b) * 33'(i_data.a);
    end

    always_comb begin
        w_r255 = {r_s5.ca_r, 8'd0} - 41'(r_s5.ca_r);
        w_g255 = {r_s5.ca_g, 8'd0} - 41'(r_s5.ca_g);
        w_b255 = {r_s5.ca_b, 8'd0} - 41'(r_s5.ca_b);
        if (r_s5.trace) begin
            n_s6 = '0;
        end else begin
            n_s6.alpha_byte = r_s5.alpha;
            n_s6.red_byte   = w_r255[39:32];
            n_s6.green_byte = w_g255[39:32];
            n_s6.blue_byte  = w_b255[39:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy5) r_v5 <= i_valid;
            if (w_rdy6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && i_valid) r_s5 <= n_s5;
        if (w_rdy6 && r_v5)    r_s6 <= n_s6;
    end

endmodule
